/* rtl/core/fagr_pkg.sv */
// Package for the fraction arithmetic block with gcd reduction.
// Holds the operand and result widths, the operation codes and the payload structs.
// No dependencies.
`default_nettype none

package fagr_pkg;

  // Operand width of each fraction field
  localparam int unsigned OPERAND_WIDTH = 16;
  // Result widths
  localparam int unsigned NUM_W = 33;
  localparam int unsigned DEN_W = 32;
  // Product of two operands
  localparam int unsigned PROD_W = 2 * OPERAND_WIDTH;
  // Counter width, holds 0 .. NUM_W
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_EQ  = 2'd2,
    OP_INC = 2'd3
  } op_e;

  typedef struct packed {
    op_e                      operation;
    logic [OPERAND_WIDTH-1:0] a_num;
    logic [OPERAND_WIDTH-1:0] a_den;
    logic [OPERAND_WIDTH-1:0] b_num;
    logic [OPERAND_WIDTH-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic [NUM_W-1:0] res_num;
    logic [DEN_W-1:0] res_den;
    logic             equal;
    logic             error;
  } out_t;

endpackage

`default_nettype wire

/* rtl/core/fraction_arith_gcd_reduce.sv */
// Fraction add, multiply, increment and compare, with the result reduced by its gcd.
// One shared multiplier builds the products; one shared subtractor runs gcd and division.
// Depends on fagr_pkg.
//   Flow: a compare is decided in the first multiply step; a zero numerator or zero denominator
//   skips the gcd; other items take 3 multiply steps on the one multiplier, then a binary gcd
//   and two 33-step restoring divisions, both through the one subtractor.
//   Throughput: one item at a time; in_ready_o is high only while the sequencer idles.
//   Reset: rst_ni asynchronous, active low; clears the sequencer and the output valid.
`default_nettype none

module fraction_arith_gcd_reduce (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire fagr_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output fagr_pkg::out_t      out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_GCD,
    S_DIV,
    S_OUT
  } state_e;

  state_e                                 state_q;
  logic [1:0]                             step_q;
  fagr_pkg::in_t                          in_q;
  logic [fagr_pkg::NUM_W-1:0]             n_q;
  logic [fagr_pkg::DEN_W-1:0]             d_q;
  logic                                   eq_q;
  logic                                   err_q;
  logic [fagr_pkg::NUM_W-1:0]             u_q;
  logic [fagr_pkg::NUM_W-1:0]             v_q;
  logic [fagr_pkg::CNT_W-1:0]             k_q;
  logic [fagr_pkg::NUM_W-1:0]             g_q;
  logic [fagr_pkg::NUM_W-1:0]             rem_q;
  logic [fagr_pkg::NUM_W-1:0]             quo_q;
  logic [fagr_pkg::CNT_W-1:0]             cnt_q;
  logic                                   den_phase_q;
  fagr_pkg::out_t                         out_q;
  logic                                   out_valid_q;

  logic [fagr_pkg::OPERAND_WIDTH-1:0]     mul_a;
  logic [fagr_pkg::OPERAND_WIDTH-1:0]     mul_b;
  logic [fagr_pkg::PROD_W-1:0]            prod;
  logic [fagr_pkg::NUM_W-1:0]             sub_a;
  logic [fagr_pkg::NUM_W-1:0]             sub_b;
  logic [fagr_pkg::NUM_W:0]               diff;
  logic [fagr_pkg::NUM_W:0]               neg_diff;
  logic                                   ge;
  logic [fagr_pkg::NUM_W-1:0]             shifted;
  logic [fagr_pkg::NUM_W-1:0]             quo_next;
  logic                                   div_last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Select multiplier operands by step
  always_comb begin
    unique case (step_q)
      2'd0: begin
        mul_a = in_q.a_num;
        mul_b = (in_q.operation == fagr_pkg::OP_ADD) ? in_q.b_den : in_q.b_num;
      end
      2'd1: begin
        mul_a = in_q.b_num;
        mul_b = in_q.a_den;
      end
      default: begin
        mul_a = in_q.a_den;
        mul_b = in_q.b_den;
      end
    endcase
  end

  assign prod = fagr_pkg::PROD_W'(mul_a) * fagr_pkg::PROD_W'(mul_b);

  // Shared subtractor: gcd difference or division trial subtract
  assign shifted = {rem_q[fagr_pkg::NUM_W-2:0], quo_q[fagr_pkg::NUM_W-1]};

  always_comb begin
    if (state_q == S_DIV) begin
      sub_a = shifted;
      sub_b = g_q;
    end else begin
      sub_a = u_q;
      sub_b = v_q;
    end
  end

  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign neg_diff = ~diff + {{fagr_pkg::NUM_W{1'b0}}, 1'b1};
  assign ge       = ~diff[fagr_pkg::NUM_W];
  assign quo_next = {quo_q[fagr_pkg::NUM_W-2:0], ge};
  assign div_last = (cnt_q == fagr_pkg::CNT_W'(fagr_pkg::NUM_W - 1));

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 2'd0;
      in_q        <= '0;
      n_q         <= '0;
      d_q         <= '0;
      eq_q        <= 1'b0;
      err_q       <= 1'b0;
      u_q         <= '0;
      v_q         <= '0;
      k_q         <= '0;
      g_q         <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      den_phase_q <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the result once transferred
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            step_q  <= 2'd0;
            eq_q    <= 1'b0;
            err_q   <= 1'b0;
            state_q <= S_MUL;
          end
        end

        S_MUL: begin
          unique case (step_q)
            2'd0: begin
              if (in_q.operation == fagr_pkg::OP_EQ) begin
                eq_q    <= (in_q.a_num == in_q.b_num) && (in_q.a_den == in_q.b_den);
                n_q     <= '0;
                d_q     <= '0;
                state_q <= S_OUT;
              end else begin
                n_q    <= fagr_pkg::NUM_W'(prod);
                step_q <= 2'd1;
              end
            end
            2'd1: begin
              if (in_q.operation == fagr_pkg::OP_ADD) begin
                n_q <= n_q + fagr_pkg::NUM_W'(prod);
              end
              step_q <= 2'd2;
            end
            default: begin
              if (in_q.operation == fagr_pkg::OP_INC) begin
                n_q <= fagr_pkg::NUM_W'(in_q.a_num) + fagr_pkg::NUM_W'(in_q.a_den);
                d_q <= fagr_pkg::DEN_W'(in_q.a_den);
              end else begin
                d_q <= fagr_pkg::DEN_W'(prod);
              end
              step_q  <= 2'd0;
              state_q <= S_CHECK;
            end
          endcase
        end

        S_CHECK: begin
          if (d_q == '0) begin
            err_q   <= 1'b1;
            n_q     <= '0;
            state_q <= S_OUT;
          end else if (n_q == '0) begin
            state_q <= S_OUT;
          end else begin
            u_q     <= n_q;
            v_q     <= fagr_pkg::NUM_W'(d_q);
            k_q     <= '0;
            state_q <= S_GCD;
          end
        end

        // Binary gcd: strip common twos, then subtract odd values
        S_GCD: begin
          if (u_q == '0 || v_q == '0) begin
            g_q         <= (u_q | v_q) << k_q;
            rem_q       <= '0;
            quo_q       <= n_q;
            cnt_q       <= '0;
            den_phase_q <= 1'b0;
            state_q     <= S_DIV;
          end else if (!u_q[0] && !v_q[0]) begin
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
            k_q <= k_q + fagr_pkg::CNT_W'(1);
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (ge) begin
            u_q <= diff[fagr_pkg::NUM_W-1:0];
          end else begin
            v_q <= neg_diff[fagr_pkg::NUM_W-1:0];
          end
        end

        // Restoring division, one quotient bit a cycle
        S_DIV: begin
          rem_q <= ge ? diff[fagr_pkg::NUM_W-1:0] : shifted;
          quo_q <= quo_next;
          cnt_q <= cnt_q + fagr_pkg::CNT_W'(1);
          if (div_last) begin
            if (!den_phase_q) begin
              n_q         <= quo_next;
              rem_q       <= '0;
              quo_q       <= fagr_pkg::NUM_W'(d_q);
              cnt_q       <= '0;
              den_phase_q <= 1'b1;
            end else begin
              d_q     <= fagr_pkg::DEN_W'(quo_next);
              state_q <= S_OUT;
            end
          end
        end

        // Hold until the output register is free
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.res_num <= n_q;
            out_q.res_den <= d_q;
            out_q.equal   <= eq_q;
            out_q.error   <= err_q;
            out_valid_q   <= 1'b1;
            state_q       <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // An error result carries a zero fraction
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.res_num == '0 && out_data_o.res_den == '0)
    else $error("error result with nonzero fraction");

  // A compare result never flags an error and has a zero numerator
  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.equal |-> !out_data_o.error && out_data_o.res_num == '0)
    else $error("compare result mixed with arithmetic result");

  // The gcd loop never sees both values at zero
  a_gcd_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_GCD |-> (u_q != '0 || v_q != '0))
    else $error("gcd operands both zero");

  // The divisor is never zero
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> g_q != '0)
    else $error("division by zero");

  // A transferred result is not repeated unless a new one is loaded
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && state_q != S_OUT |=> !out_valid_o)
    else $error("result repeated after transfer");

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for fraction_arith_gcd_reduce: add, multiply, compare, increment.
// Predicts each reduced fraction in a scoreboard class and checks every output transfer.
// Depends on fagr_pkg and the RTL of fraction_arith_gcd_reduce.

module testbench;
  import fagr_pkg::*;

  // Predict reduced fractions and compare them against the block's output
  class fraction_checker;
    out_t expected_fracs[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // Reduce the arithmetic result by its gcd; compare only looks at raw fields
    function out_t predict_fraction(in_t req);
      bit [63:0] an, ad, bn, bd, n, d, x, y, t;
      out_t r;
      an = 64'(req.a_num);
      ad = 64'(req.a_den);
      bn = 64'(req.b_num);
      bd = 64'(req.b_den);
      n = '0;
      d = '0;
      r = '0;
      if (req.operation == OP_EQ) begin
        r.equal = (an == bn) && (ad == bd);
      end else begin
        case (req.operation)
          OP_ADD: begin
            n = an * bd + bn * ad;
            d = ad * bd;
          end
          OP_MUL: begin
            n = an * bn;
            d = ad * bd;
          end
          default: begin
            n = an + ad;
            d = ad;
          end
        endcase
        if (d == 0) begin
          r.error = 1'b1;
          n = '0;
        end else if (n != 0) begin
          x = n;
          y = d;
          while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
          end
          n = n / x;
          d = d / x;
        end
        r.res_num = n[NUM_W-1:0];
        r.res_den = d[DEN_W-1:0];
      end
      return r;
    endfunction

    function void note_request(in_t req);
      expected_fracs.push_back(predict_fraction(req));
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (expected_fracs.size() == 0) begin
        $display("%0t: unexpected result, got %0h", $time, got);
        errors++;
        return;
      end
      e = expected_fracs.pop_front();
      if (got.res_num !== e.res_num) begin
        $display("%0t: res_num expected %0h, got %0h", $time, e.res_num, got.res_num);
        errors++;
      end
      if (got.res_den !== e.res_den) begin
        $display("%0t: res_den expected %0h, got %0h", $time, e.res_den, got.res_den);
        errors++;
      end
      if (got.equal !== e.equal) begin
        $display("%0t: equal expected %0b, got %0b", $time, e.equal, got.equal);
        errors++;
      end
      if (got.error !== e.error) begin
        $display("%0t: error expected %0b, got %0b", $time, e.error, got.error);
        errors++;
      end
    endfunction

    function int pending();
      return expected_fracs.size();
    endfunction

    // Count expectations that never got a result
    function void close_out();
      if (expected_fracs.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, expected_fracs.size());
        errors += expected_fracs.size();
      end
    endfunction
  endclass

  localparam int HOLD_CYCLES = 600;

  bit   clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  fraction_checker board;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  fraction_arith_gcd_reduce dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Check each output transfer, then drive ready: long hold-off, random stall or accept
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(out_data_o);
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      out_ready_i <= 1'b0;
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic in_t make_item(op_e op, int an, int ad, int bn, int bd);
    in_t r;
    r.operation = op;
    r.a_num = OPERAND_WIDTH'(an);
    r.a_den = OPERAND_WIDTH'(ad);
    r.b_num = OPERAND_WIDTH'(bn);
    r.b_den = OPERAND_WIDTH'(bd);
    return r;
  endfunction

  // Mix zeros, all-ones, tiny values, values with shared factors and full-range values
  function automatic logic [OPERAND_WIDTH-1:0] pick_field(bit is_den);
    int sel;
    sel = $urandom_range(19);
    case (sel)
      0:        return '0;
      1:        return is_den ? OPERAND_WIDTH'($urandom) : '0;
      2, 3:     return '1;
      4, 5, 6:  return OPERAND_WIDTH'($urandom_range(1, 12));
      7, 8, 9:  return OPERAND_WIDTH'($urandom_range(1, 200) * $urandom_range(1, 200));
      default:  return OPERAND_WIDTH'($urandom);
    endcase
  endfunction

  function automatic in_t random_item();
    in_t r;
    int sel;
    r.operation = op_e'($urandom_range(3));
    r.a_num = pick_field(1'b0);
    r.a_den = pick_field(1'b1);
    r.b_num = pick_field(1'b0);
    r.b_den = pick_field(1'b1);
    // Compare needs matching fields often enough to see both answers
    if (r.operation == OP_EQ) begin
      sel = $urandom_range(3);
      if (sel < 2) begin
        r.b_num = r.a_num;
        r.b_den = r.a_den;
      end else if (sel == 2) begin
        if ($urandom_range(1)) r.b_num = r.a_num;
        else r.b_den = r.a_den;
      end
    end
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then idle at random
  task automatic offer_fraction(in_t req);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stop offering and wait for every expected result, then let the block settle
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (board.pending() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (160) @(posedge clk_i);
  endtask

  task automatic run_random(int count, int idle, int stall);
    send_idle_pct = idle;
    stall_pct <= stall;
    repeat (count) offer_fraction(random_item());
    drain_results();
  endtask

  // Hang guard
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    in_t directed[$];
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: extremes, every operation, zero numerators and zero denominators
    directed.push_back(make_item(OP_ADD, 1, 2, 1, 3));
    directed.push_back(make_item(OP_ADD, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
    directed.push_back(make_item(OP_ADD, 'hFFFF, 'hFFFE, 'hFFFF, 'hFFFD));
    directed.push_back(make_item(OP_ADD, 65521, 65519, 65519, 65521));
    directed.push_back(make_item(OP_ADD, 0, 5, 0, 7));
    directed.push_back(make_item(OP_ADD, 1, 0, 1, 3));
    directed.push_back(make_item(OP_ADD, 1, 3, 1, 0));
    directed.push_back(make_item(OP_MUL, 2, 3, 3, 4));
    directed.push_back(make_item(OP_MUL, 'hFFFF, 1, 'hFFFF, 1));
    directed.push_back(make_item(OP_MUL, 0, 'hFFFF, 'h1234, 'hFFFF));
    directed.push_back(make_item(OP_MUL, 5, 0, 7, 0));
    directed.push_back(make_item(OP_MUL, 1, 1, 1, 1));
    directed.push_back(make_item(OP_EQ, 'h1234, 'h5678, 'h1234, 'h5678));
    directed.push_back(make_item(OP_EQ, 'h1234, 'h5678, 'h1235, 'h5678));
    directed.push_back(make_item(OP_EQ, 'h1234, 'h5678, 'h1234, 'h5679));
    directed.push_back(make_item(OP_EQ, 0, 0, 0, 0));
    directed.push_back(make_item(OP_EQ, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
    directed.push_back(make_item(OP_EQ, 1, 2, 2, 4));
    directed.push_back(make_item(OP_INC, 3, 4, 0, 0));
    directed.push_back(make_item(OP_INC, 'hFFFF, 'hFFFF, 'hAAAA, 'h5555));
    directed.push_back(make_item(OP_INC, 0, 5, 'hFFFF, 0));
    directed.push_back(make_item(OP_INC, 7, 0, 1, 1));
    directed.push_back(make_item(OP_INC, 'hFFFF, 1, 'hFFFF, 'hFFFF));
    foreach (directed[i]) offer_fraction(directed[i]);
    drain_results();

    // Random phases with different idling on each side
    run_random(250, 0, 0);
    run_random(220, 64, 0);
    run_random(220, 0, 64);
    run_random(210, 19, 19);

    // Long receiver hold-off while the sender keeps offering, so the block backs up
    send_idle_pct = 0;
    stall_pct <= 0;
    hold_seq <= hold_seq + 1;
    repeat (12) offer_fraction(random_item());
    drain_results();

    board.close_out();
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
